// ===== hw/rtl/cte_pkg.sv =====
// cte_pkg: shared types and constants for the command token extractor
// no dependencies; used by cte_step and command_token_extractor
`timescale 1ns / 1ps
`default_nettype none

package cte_pkg;

    // character codes
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // scan modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_QUOTED = 2'd2;

    // configuration register indexes
    localparam logic REG_TOKEN_SELECT = 1'b0;
    localparam logic REG_COUNT_ONLY   = 1'b1;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0] mode;
        logic       escape;
        logic [7:0] code_accum;
        logic       code_pending;
        logic [7:0] tokens_seen;
        logic       stopped;
    } scan_state_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_value;
        logic       line_done;
        logic [7:0] token_count;
        logic       token_found;
    } scan_result_t;

    localparam scan_state_t SCAN_STATE_RESET = '{
        mode:         MODE_IDLE,
        escape:       1'b0,
        code_accum:   8'd0,
        code_pending: 1'b0,
        tokens_seen:  8'd0,
        stopped:      1'b0
    };

endpackage

`default_nettype wire

// ===== hw/rtl/cte_step.sv =====
// cte_step: combinational next-state and result logic for one character
// depends on cte_pkg
`timescale 1ns / 1ps
`default_nettype none

module cte_step (
    input  wire logic [7:0]           ch,
    input  wire logic                 last,
    input  wire logic [7:0]           token_select,
    input  wire logic                 count_only,
    input  wire cte_pkg::scan_state_t state_cur,
    output cte_pkg::scan_state_t      state_nxt,
    output cte_pkg::scan_result_t     result
);
    import cte_pkg::*;

    logic        is_quote;
    logic        is_digit;
    logic        work;
    logic        ended;
    logic        selected;
    logic        out_valid;
    logic [7:0]  out_value;
    logic [7:0]  digit;
    logic [8:0]  select_plus;
    scan_state_t s;

    assign is_quote    = (ch == CH_DQUOTE) || (ch == CH_SQUOTE);
    assign is_digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit       = ch - CH_ZERO;
    assign select_plus = {1'b0, token_select} + 9'd1;

    always_comb
    begin
        s         = state_cur;
        work      = 1'b1;
        ended     = 1'b0;
        selected  = 1'b0;
        out_valid = 1'b0;
        out_value = 8'd0;

        if (!state_cur.stopped)
        begin
            // start of a token
            if (s.mode != MODE_WORD && s.mode != MODE_QUOTED)
            begin
                s.mode = MODE_IDLE;
                if (is_quote || ch != CH_SPACE)
                begin
                    s.mode = is_quote ? MODE_QUOTED : MODE_WORD;
                    if (s.tokens_seen != COUNT_MAX)
                    begin
                        s.tokens_seen = s.tokens_seen + 8'd1;
                    end
                end
                // opening quote and separator spaces carry no character
                if (is_quote || ch == CH_SPACE)
                begin
                    work = 1'b0;
                end
            end

            if (work)
            begin
                if (!s.escape)
                begin
                    if (s.mode == MODE_QUOTED && is_quote)
                    begin
                        ended = 1'b1;
                    end
                    else if (s.mode == MODE_WORD && ch == CH_SPACE)
                    begin
                        ended = 1'b1;
                    end
                    else if (ch == CH_BSLASH)
                    begin
                        s.escape = 1'b1;
                        work     = 1'b0;
                    end
                end
                else if (!is_digit)
                begin
                    s.escape = 1'b0;
                end
            end

            if (work)
            begin
                selected = ({1'b0, s.tokens_seen} == select_plus);
                priority if (ended)
                begin
                    s.mode = MODE_IDLE;
                    if (!count_only && selected)
                    begin
                        s.stopped = 1'b1;
                    end
                end
                else if (s.escape && is_digit)
                begin
                    // accum * 10 + digit, wrapping at 8 bits
                    s.code_accum   = (s.code_accum << 3) + (s.code_accum << 1) + digit;
                    s.code_pending = 1'b1;
                end
                else
                begin
                    if (!count_only && selected)
                    begin
                        out_valid = 1'b1;
                        out_value = s.code_pending ? s.code_accum : ch;
                    end
                    s.code_pending = 1'b0;
                    s.code_accum   = 8'd0;
                end
            end
        end

        result.char_valid  = out_valid;
        result.char_value  = out_value;
        result.line_done   = last;
        result.token_count = s.tokens_seen;
        result.token_found = ({1'b0, s.tokens_seen} == select_plus);

        // end of line returns the scanner to its reset state
        state_nxt = last ? SCAN_STATE_RESET : s;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/command_token_extractor.sv =====
// command_token_extractor: top level, input stage, scanner state and output register
// depends on cte_pkg and cte_step
// path from input accept to m_tvalid: input register, then result register
// throughput: one item per cycle while m_tready is high, limited by the scanner state update
// the input stage keeps accepting while a result waits, until both stages are full
// reset (rst_n low, asynchronous): stages empty, scanner state and config registers cleared
`timescale 1ns / 1ps
`default_nettype none

module command_token_extractor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,   // 0 token_select, 1 count_only
    input  wire logic [7:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] ch
    input  wire logic        s_tlast,    // last character of the line
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // [7:0] char_value, [15:8] token_count,
                                         // [16] token_found, [23:17] zero
    output logic             m_tuser,    // char_valid
    output logic             m_tlast     // line_done
);
    import cte_pkg::*;

    // configuration registers
    logic [7:0]   token_select_reg;
    logic         count_only_reg;

    // input stage
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_ch_reg;
    logic         in_last_reg;

    // scanner state
    scan_state_t  state_reg;
    scan_state_t  state_next;

    // result register
    logic         out_valid_reg;
    logic         out_valid_next;
    scan_result_t out_reg;
    scan_result_t step_result;

    logic         advance;   // result register can take a new item
    logic         fire;      // input stage item is processed this cycle
    logic         in_take;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // in_valid stays set when a new item replaces the one leaving
    assign in_valid_next  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // configuration writes; the user must issue them only while the block is idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_select_reg <= 8'd0;
            count_only_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TOKEN_SELECT: token_select_reg <= cfg_data;
                REG_COUNT_ONLY:   count_only_reg   <= cfg_data[0];
                default:          token_select_reg <= token_select_reg;
            endcase
        end
    end

    // per-character scanner logic
    cte_step u_step (
        .ch           (in_ch_reg),
        .last         (in_last_reg),
        .token_select (token_select_reg),
        .count_only   (count_only_reg),
        .state_cur    (state_reg),
        .state_nxt    (state_next),
        .result       (step_result)
    );

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SCAN_STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload flops, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.token_found, out_reg.token_count, out_reg.char_value};
    assign m_tuser  = out_reg.char_valid;
    assign m_tlast  = out_reg.line_done;

endmodule

`default_nettype wire
